FILE: rtl/rme_pkg.sv
package rme_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int IN_W        = 18;
  localparam int ANG_W       = 19;
  localparam int THR_W       = 17;
  localparam int SQ_W        = 2 * IN_W;        // one square of an entry
  localparam int ROOT_W      = IN_W;            // floor sqrt of the sum of two squares
  localparam int REM_W       = ROOT_W + 3;
  localparam int SQ_STAGES   = ROOT_W;          // one result bit per cell
  localparam int CORD_STAGES = 32;
  localparam int PRESCALE    = 20;
  localparam int XY_W        = 42;
  localparam int Z_W         = 36;
  localparam int SH          = 32 - FRAC_BITS;
  localparam int NLANE       = 3;
  localparam int LANE_ROLL   = 0;
  localparam int LANE_PITCH  = 1;
  localparam int LANE_YAW    = 2;

  localparam logic signed [Z_W-1:0] PI_Q32 = 36'sd13493037705;
  localparam logic signed [Z_W-1:0] HALF   = Z_W'(64'(1) << (SH - 1));
  localparam logic signed [Z_W-1:0] PIQ    = (PI_Q32 + HALF) >>> SH;

  localparam logic [1:0] BASE_NONE  = 2'd0;
  localparam logic [1:0] BASE_PLUS  = 2'd1;
  localparam logic [1:0] BASE_MINUS = 2'd2;

  // atan(2^-i) in Q.32, rounded to nearest
  localparam logic [31:0] ATAN_TBL [CORD_STAGES] = '{
    32'd3373259426, 32'd1991351317, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  typedef struct packed {
    logic signed [IN_W-1:0] r00;
    logic signed [IN_W-1:0] r10;
    logic signed [IN_W-1:0] r20;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
  } ent_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    ent_t              ent;
  } sq_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             base;
    logic                   yzero;
    logic                   xneg;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] lane;
    logic              sing;
  } cord_t;

  // quadrant fold and prescale ahead of the vectoring stages
  function automatic lane_t lane_init(logic signed [IN_W:0] y, logic signed [IN_W:0] x);
    lane_t l;
    logic signed [IN_W:0] xa;
    logic signed [IN_W:0] ya;
    l.yzero = (y == '0);
    l.xneg  = x[IN_W];
    l.base  = BASE_NONE;
    xa = x;
    ya = y;
    if (x[IN_W]) begin
      l.base = y[IN_W] ? BASE_MINUS : BASE_PLUS;
      xa = -x;
      ya = -y;
    end
    l.x = XY_W'(xa) <<< PRESCALE;
    l.y = XY_W'(ya) <<< PRESCALE;
    l.z = '0;
    return l;
  endfunction

  // base + z to Q3.FRAC_BITS, round half up, clamp to +-pi
  function automatic logic signed [ANG_W-1:0] ang_out(lane_t l);
    logic signed [Z_W-1:0] a;
    logic signed [Z_W-1:0] r;
    a = l.z;
    if (l.base == BASE_PLUS) begin
      a = l.z + PI_Q32;
    end else if (l.base == BASE_MINUS) begin
      a = l.z - PI_Q32;
    end
    r = (a + HALF) >>> SH;
    if (r > PIQ) begin
      r = PIQ;
    end
    if (r < -PIQ) begin
      r = -PIQ;
    end
    if (l.yzero) begin
      r = l.xneg ? PIQ : '0;
    end
    return ANG_W'(r);
  endfunction

endpackage

FILE: rtl/rotation_matrix_to_euler_angles_core.sv
// Pipeline: input reg, squares, 18 square-root cells, quadrant prep,
//   32 CORDIC cells, output reg, each a registered stage.
// Throughput: one item per cycle while results are taken; every stage is a
//   cell with its own valid bit, so bubbles close up and a waiting result
//   stalls the input only once every stage holds an item.
// Reset (rst, synchronous, active high) empties all stages and sets the
//   singular threshold to 1.
module rotation_matrix_to_euler_angles_core
  import rme_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input item
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // r00, r10, r20, r21, r22, r11, r12 (18b each), 2b zero
  // result item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // roll, pitch, yaw (19b each), 7b zero
  output logic [0:0]   m_axis_tuser,   // singular
  // threshold register write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [16:0]  cfg_data        // singular_threshold, Q1.16
);

  logic [THR_W-1:0] thr;

  // stage ready signals, each looks at the stage after it
  logic                 mul_rdy;
  logic [SQ_STAGES:0]   sq_rdy;
  logic [CORD_STAGES:0] cd_rdy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_W'(1);
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // ---- input register ----
  logic in_v;
  ent_t in_e;
  logic in_rdy;
  assign in_rdy        = !in_v || mul_rdy;
  assign s_axis_tready = in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_rdy) begin
      in_v <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && s_axis_tvalid) begin
      in_e.r00 <= s_axis_tdata[17:0];
      in_e.r10 <= s_axis_tdata[35:18];
      in_e.r20 <= s_axis_tdata[53:36];
      in_e.r21 <= s_axis_tdata[71:54];
      in_e.r22 <= s_axis_tdata[89:72];
      in_e.r11 <= s_axis_tdata[107:90];
      in_e.r12 <= s_axis_tdata[125:108];
    end
  end

  // ---- squares of r00 and r10 ----
  logic                   mul_v;
  ent_t                   mul_e;
  logic signed [SQ_W-1:0] sq00;
  logic signed [SQ_W-1:0] sq10;

  assign mul_rdy = !mul_v || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (mul_rdy) begin
      mul_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_rdy && in_v) begin
      sq00  <= in_e.r00 * in_e.r00;
      sq10  <= in_e.r10 * in_e.r10;
      mul_e <= in_e;
    end
  end

  // ---- square root chain: one root bit per cell ----
  logic [SQ_STAGES:0] sq_v;
  sq_t                sq_d [SQ_STAGES+1];

  always_comb begin
    sq_d[0].rad  = $unsigned(sq00) + $unsigned(sq10);  // at most 2^35, fits
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
    sq_d[0].ent  = mul_e;
  end
  assign sq_v[0] = mul_v;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
    rme_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sq_v[g]),
      .in_ready (sq_rdy[g]),
      .in_data  (sq_d[g]),
      .out_valid(sq_v[g+1]),
      .out_ready(sq_rdy[g+1]),
      .out_data (sq_d[g+1])
    );
  end

  // ---- prep: threshold compare, roll branch, quadrant fold ----
  logic  prep_v;
  cord_t prep_d;
  cord_t prep_next;
  ent_t  e;
  logic  sing;

  assign sq_rdy[SQ_STAGES] = !prep_v || cd_rdy[0];

  always_comb begin
    e    = sq_d[SQ_STAGES].ent;
    sing = sq_d[SQ_STAGES].root < ROOT_W'(thr);
    prep_next.sing = sing;
    prep_next.lane[LANE_PITCH] = lane_init(-$signed({e.r20[IN_W-1], e.r20}),
                                           $signed({1'b0, sq_d[SQ_STAGES].root}));
    prep_next.lane[LANE_YAW]   = lane_init($signed({e.r10[IN_W-1], e.r10}),
                                           $signed({e.r00[IN_W-1], e.r00}));
    if (sing) begin
      prep_next.lane[LANE_ROLL] = lane_init(-$signed({e.r12[IN_W-1], e.r12}),
                                            $signed({e.r11[IN_W-1], e.r11}));
    end else begin
      prep_next.lane[LANE_ROLL] = lane_init($signed({e.r21[IN_W-1], e.r21}),
                                            $signed({e.r22[IN_W-1], e.r22}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_v <= 1'b0;
    end else if (sq_rdy[SQ_STAGES]) begin
      prep_v <= sq_v[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (sq_rdy[SQ_STAGES] && sq_v[SQ_STAGES]) begin
      prep_d <= prep_next;
    end
  end

  // ---- CORDIC chain: one iteration per cell, three lanes side by side ----
  logic [CORD_STAGES:0] cd_v;
  cord_t                cd_d [CORD_STAGES+1];

  assign cd_v[0] = prep_v;
  assign cd_d[0] = prep_d;

  for (genvar g = 0; g < CORD_STAGES; g++) begin : g_cd
    rme_cordic_cell #(.STAGE(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cd_v[g]),
      .in_ready (cd_rdy[g]),
      .in_data  (cd_d[g]),
      .out_valid(cd_v[g+1]),
      .out_ready(cd_rdy[g+1]),
      .out_data (cd_d[g+1])
    );
  end

  // ---- output register: rounding, clamp, yaw forced to zero when singular ----
  logic                    out_v;
  logic signed [ANG_W-1:0] roll;
  logic signed [ANG_W-1:0] pitch;
  logic signed [ANG_W-1:0] yaw;
  logic                    out_sing;

  assign cd_rdy[CORD_STAGES] = !out_v || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cd_rdy[CORD_STAGES]) begin
      out_v <= cd_v[CORD_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (cd_rdy[CORD_STAGES] && cd_v[CORD_STAGES]) begin
      roll     <= ang_out(cd_d[CORD_STAGES].lane[LANE_ROLL]);
      pitch    <= ang_out(cd_d[CORD_STAGES].lane[LANE_PITCH]);
      yaw      <= cd_d[CORD_STAGES].sing ? '0 : ang_out(cd_d[CORD_STAGES].lane[LANE_YAW]);
      out_sing <= cd_d[CORD_STAGES].sing;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = {7'd0, yaw, pitch, roll};
  assign m_axis_tuser  = out_sing;

  // ---- checks ----
  a_yaw_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> yaw == '0)
    else $error("yaw nonzero on singular item");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> roll <= ANG_W'(PIQ) && roll >= -ANG_W'(PIQ))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pitch <= ANG_W'(PIQ) && pitch >= -ANG_W'(PIQ))
    else $error("pitch out of range");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_v && m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while pipeline has room");

endmodule

FILE: rtl/rme_sqrt_cell.sv
// One digit of the restoring square root: two radicand bits in, one root bit out.
module rme_sqrt_cell
  import rme_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t  out_data
);

  logic             valid;
  sq_t              data;
  sq_t              data_next;
  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;

  always_comb begin
    rem2  = {in_data.rem[REM_W-3:0], in_data.rad[SQ_W-1 -: 2]};
    trial = REM_W'({in_data.root, 2'b01});
    data_next      = in_data;
    data_next.rad  = in_data.rad << 2;
    if (rem2 >= trial) begin
      data_next.rem  = rem2 - trial;
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_next.rem  = rem2;
      data_next.root = {in_data.root[ROOT_W-2:0], 1'b0};
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: rtl/rme_cordic_cell.sv
// One vectoring CORDIC iteration, applied to all three angle lanes.
module rme_cordic_cell
  import rme_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cord_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output cord_t out_data
);

  localparam logic signed [Z_W-1:0] ANG = $signed({{(Z_W-32){1'b0}}, ATAN_TBL[STAGE]});

  logic  valid;
  cord_t data;
  cord_t data_next;

  always_comb begin
    data_next = in_data;
    for (int k = 0; k < NLANE; k++) begin
      if (!in_data.lane[k].y[XY_W-1]) begin
        data_next.lane[k].x = in_data.lane[k].x + (in_data.lane[k].y >>> STAGE);
        data_next.lane[k].y = in_data.lane[k].y - (in_data.lane[k].x >>> STAGE);
        data_next.lane[k].z = in_data.lane[k].z + ANG;
      end else begin
        data_next.lane[k].x = in_data.lane[k].x - (in_data.lane[k].y >>> STAGE);
        data_next.lane[k].y = in_data.lane[k].y + (in_data.lane[k].x >>> STAGE);
        data_next.lane[k].z = in_data.lane[k].z - ANG;
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import rme_pkg::*;

  localparam int NUM_RANDOM = 600;
  localparam int DRAIN_WAIT = 80;
  localparam int HOLD_OFF   = 300;

  localparam longint PI_Q32_L = 64'sd13493037705;
  localparam longint ANG_BIAS = 64'sd17179869184;

  typedef struct {
    logic signed [ANG_W-1:0] roll;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic                    singular;
  } euler_t;

  // Expected-angle queue plus the predictor for one matrix.
  class euler_scoreboard;
    euler_t      pending[$];
    int          errors;
    logic [16:0] threshold;

    function new();
      errors    = 0;
      threshold = 17'd1;
    endfunction

    function longint atan_q32(int i);
      return longint'(ATAN_TBL[i]);
    endfunction

    function logic signed [ANG_W-1:0] to_q16(longint a);
      longint half;
      longint piq;
      longint r;
      half = 64'sd1 << (SH - 1);
      piq  = (PI_Q32_L + half) >>> SH;
      r = ((a + ANG_BIAS + half) >>> SH) - (ANG_BIAS >>> SH);
      if (r > piq) r = piq;
      if (r < -piq) r = -piq;
      return ANG_W'(r);
    endfunction

    function logic signed [ANG_W-1:0] vec_atan2(longint y, longint x);
      longint base;
      longint z;
      longint dx;
      longint dy;
      base = 0;
      z    = 0;
      if (y == 0) return (x < 0) ? to_q16(PI_Q32_L) : '0;
      if (x < 0) begin
        base = (y > 0) ? PI_Q32_L : -PI_Q32_L;
        x = -x;
        y = -y;
      end
      x = x <<< PRESCALE;
      y = y <<< PRESCALE;
      for (int i = 0; i < CORD_STAGES; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y >= 0) begin
          x += dy; y -= dx; z += atan_q32(i);
        end else begin
          x -= dy; y += dx; z -= atan_q32(i);
        end
      end
      return to_q16(base + z);
    endfunction

    function longint floor_sqrt(longint v);
      longint res;
      longint b;
      res = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >>> 1) + b;
        end else begin
          res = res >>> 1;
        end
        b = b >>> 2;
      end
      return res;
    endfunction

    function void note_matrix(ent_t m);
      euler_t e;
      longint sy;
      sy = floor_sqrt(longint'(m.r00) * m.r00 + longint'(m.r10) * m.r10);
      e.singular = (sy < longint'(threshold));
      e.pitch = vec_atan2(-longint'(m.r20), sy);
      if (!e.singular) begin
        e.roll = vec_atan2(m.r21, m.r22);
        e.yaw  = vec_atan2(m.r10, m.r00);
      end else begin
        e.roll = vec_atan2(-longint'(m.r12), m.r11);
        e.yaw  = '0;
      end
      pending.push_back(e);
    endfunction

    function void check_angles(logic [63:0] data, logic flag);
      euler_t e;
      logic signed [ANG_W-1:0] r, p, y;
      r = data[18:0];
      p = data[37:19];
      y = data[56:38];
      if (pending.size() == 0) begin
        $error("unexpected result item roll=%0d pitch=%0d yaw=%0d", r, p, y);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r !== e.roll) begin
        $error("roll: expected %0d, got %0d", e.roll, r); errors++;
      end
      if (p !== e.pitch) begin
        $error("pitch: expected %0d, got %0d", e.pitch, p); errors++;
      end
      if (y !== e.yaw) begin
        $error("yaw: expected %0d, got %0d", e.yaw, y); errors++;
      end
      if (flag !== e.singular) begin
        $error("singular: expected %0d, got %0d", e.singular, flag); errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // r00, r10, r20, r21, r22, r11, r12 (18b each), 2b zero
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // roll, pitch, yaw (19b each), 7b zero
  logic [0:0]   m_axis_tuser;   // singular
  logic         cfg_valid;
  logic         cfg_ready;
  logic [16:0]  cfg_data;

  euler_scoreboard sb;
  bit sink_idle_ok;   // cleared during the no-idle stretch
  bit src_idle_ok;
  bit hold_sink;

  rotation_matrix_to_euler_angles_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  // pack matrix entries, r00 in the lowest bits
  function automatic logic [127:0] pack_matrix(ent_t m);
    return {2'b00, m.r12, m.r11, m.r22, m.r21, m.r20, m.r10, m.r00};
  endfunction

  function automatic logic signed [IN_W-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 18'sh1ffff;
      1: return 18'sh20000;
      2: return '0;
      3: return IN_W'($urandom_range(0, 8) - 4);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // mostly random full-range entries with corner and small values; some with small r00, r10 for gimbal lock
  function automatic ent_t rand_matrix();
    ent_t m;
    m.r00 = rand_entry(); m.r10 = rand_entry(); m.r20 = rand_entry();
    m.r21 = rand_entry(); m.r22 = rand_entry(); m.r11 = rand_entry();
    m.r12 = rand_entry();
    if ($urandom_range(0, 3) == 0) begin
      m.r00 = IN_W'($urandom_range(0, 512) - 256);
      m.r10 = IN_W'($urandom_range(0, 512) - 256);
    end
    return m;
  endfunction

  // Sender: offers one matrix, idles at random with tvalid low.
  // tvalid stays high after an accept so items can follow back to back.
  task automatic send_matrix(ent_t m);
    while (src_idle_ok && $urandom_range(0, 99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pack_matrix(m);
    sb.note_matrix(m);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_threshold(logic [16:0] t);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.threshold = t;
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_angles(m_axis_tdata, m_axis_tuser[0]);
      m_axis_tready <= !hold_sink && !(sink_idle_ok && $urandom_range(0, 99) < 27);
    end
  end

  initial begin
    ent_t m;
    logic [16:0] thr_list[5];
    sb = new();
    thr_list = '{17'd0, 17'd65536, 17'd131071, 17'd40000, 17'd1};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    sink_idle_ok = 1'b1;
    src_idle_ok  = 1'b1;
    hold_sink    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset threshold, corner entries, zero args, lock cases
    m = '0; send_matrix(m);
    m = '{default: 18'sh1ffff}; send_matrix(m);
    m = '{default: 18'sh20000}; send_matrix(m);
    m = '0; m.r00 = 18'sh10000; m.r11 = 18'sh10000; m.r22 = 18'sh10000;
    send_matrix(m);
    m = '0; m.r00 = -18'sh10000; m.r21 = 18'sh10000; m.r22 = -18'sh10000;
    send_matrix(m);
    m = '0; m.r20 = -18'sh10000; m.r12 = 18'sh10000; m.r11 = -18'sh100;
    send_matrix(m);
    m = '0; m.r20 = 18'sh10000; m.r12 = -18'sh8000;
    send_matrix(m);
    m = '0; m.r10 = -18'sh1; m.r00 = 18'sh0; m.r21 = -18'sh1;
    send_matrix(m);
    m = '0; m.r00 = -18'sh1; m.r22 = -18'sh5; m.r11 = -18'sh3;
    send_matrix(m);
    for (int i = 0; i < 8; i++) send_matrix(rand_matrix());
    wait_drain();

    // random phases across threshold settings
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thr_list[ph]);
      if (ph == 2) begin
        sink_idle_ok = 1'b0;
        src_idle_ok  = 1'b0;
      end else begin
        sink_idle_ok = 1'b1;
        src_idle_ok  = 1'b1;
      end
      if (ph == 1) begin
        fork
          begin
            hold_sink = 1'b1;
            repeat (HOLD_OFF) @(posedge clk);
            hold_sink = 1'b0;
          end
        join_none
      end
      for (int i = 0; i < NUM_RANDOM / 5; i++) send_matrix(rand_matrix());
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
